// ===== design/chpi_pkg.sv =====
package chpi_pkg;

  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RNF     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SEP     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DAMPING = 3'd4;

  localparam logic [15:0] RNF_RESET  = 16'd8192;
  localparam logic [15:0] SEP_RESET  = 16'd16384;
  localparam logic [15:0] ZETA_RESET = 16'd2867;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int TERM_W = 62;
  localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};

  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] OMEGA_STEPS = 6'd16;
  localparam logic [DIV_CNT_W-1:0] K0_STEPS    = 6'd32;

  typedef struct packed {
    logic [15:0] rnf;
    logic [15:0] sep;
    logic [15:0] zeta;
  } gains_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_ERR,
    OP_MUL_INT,
    OP_INT_ACC,
    OP_OM_CAP,
    OP_MUL_OV,
    OP_K0_START,
    OP_K0_CAP,
    OP_MUL_KP,
    OP_MUL_KI,
    OP_MUL_TP,
    OP_MUL_T0,
    OP_MUL_T1,
    OP_TI,
    OP_ROLL,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_zero;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } stat_t;

endpackage

// ===== design/chpi_cfg.sv =====
module chpi_cfg #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [chpi_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [((ANGLE_BITS > 16) ? ANGLE_BITS : 16)-1:0] cfg_wdata,
  output logic                             enable,
  output logic                             clear,
  output logic [ANGLE_BITS-1:0]            target,
  output chpi_pkg::gains_t                 gains
);

  logic                  enable_r;
  logic [ANGLE_BITS-1:0] target_r;
  chpi_pkg::gains_t      gains_r;

  // rising enable clears the loop state
  assign clear = cfg_we && (cfg_addr == chpi_pkg::REG_ENABLE) && cfg_wdata[0] && !enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      target_r     <= '0;
      gains_r.rnf  <= chpi_pkg::RNF_RESET;
      gains_r.sep  <= chpi_pkg::SEP_RESET;
      gains_r.zeta <= chpi_pkg::ZETA_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        chpi_pkg::REG_ENABLE:  enable_r     <= cfg_wdata[0];
        chpi_pkg::REG_TARGET:  target_r     <= cfg_wdata[ANGLE_BITS-1:0];
        chpi_pkg::REG_RNF:     gains_r.rnf  <= cfg_wdata[15:0];
        chpi_pkg::REG_SEP:     gains_r.sep  <= cfg_wdata[15:0];
        chpi_pkg::REG_DAMPING: gains_r.zeta <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign enable = enable_r;
  assign target = target_r;
  assign gains  = gains_r;

endmodule

// ===== design/chpi_div.sv =====
module chpi_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [15:0]                     rem_init,
  input  logic [31:0]                     dividend_lo,
  input  logic [15:0]                     divisor,
  input  logic [chpi_pkg::DIV_CNT_W-1:0]  steps,
  output logic                            busy,
  output logic [31:0]                     quotient
);

  logic                           busy_r;
  logic [chpi_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [15:0]                    rem_r;
  logic [15:0]                    div_r;
  logic [31:0]                    lo_r;
  logic [31:0]                    q_r;
  logic [16:0]                    rem2;
  logic [16:0]                    diff;
  logic                           ge;
  logic [15:0]                    rem_nxt;

  // restoring step, one quotient bit a cycle
  assign rem2    = {rem_r, lo_r[31]};
  assign diff    = rem2 - {1'b0, div_r};
  assign ge      = rem2 >= {1'b0, div_r};
  assign rem_nxt = ge ? diff[15:0] : rem2[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - chpi_pkg::DIV_CNT_W'(1);
      if (cnt_r == chpi_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      lo_r  <= dividend_lo;
      div_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[30:0], 1'b0};
      q_r   <= {q_r[30:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// ===== design/chpi_dp.sv =====
module chpi_dp #(
  parameter int ANGLE_BITS    = 16,
  parameter int INTEGRAL_BITS = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  chpi_pkg::cmd_t                  cmd,
  output chpi_pkg::stat_t                 stat,
  input  logic                            clear,
  input  logic [ANGLE_BITS-1:0]           target,
  input  chpi_pkg::gains_t                gains,
  input  logic [ANGLE_BITS-1:0]           in_course_angle,
  input  logic [15:0]                     in_ground_speed,
  input  logic [15:0]                     in_gravity_accel,
  input  logic [15:0]                     in_time_step,
  output logic                            out_command_valid,
  output logic signed [ANGLE_BITS-1:0]    out_roll_command,
  output logic signed [ANGLE_BITS-1:0]    out_course_error,
  output logic signed [INTEGRAL_BITS-1:0] out_error_integral
);

  localparam int AB     = ANGLE_BITS;
  localparam int IB     = INTEGRAL_BITS;
  localparam int PROD_W = AB + 18;
  localparam int SW     = ((IB > PROD_W) ? IB : PROD_W) + 1;
  localparam logic signed [SW-1:0] IMAX = SW'({1'b0, {(IB-1){1'b1}}});
  localparam logic signed [SW-1:0] IMIN = ~IMAX;
  localparam logic signed [63:0]   RMAX = 64'({1'b0, {(AB-1){1'b1}}});
  localparam logic signed [63:0]   RMIN = ~RMAX;

  logic [AB-1:0]        course_r;
  logic [15:0]          speed_r;
  logic [15:0]          grav_r;
  logic [15:0]          dt_r;
  logic signed [AB-1:0] e_r;
  logic signed [AB-1:0] prev_r;
  logic signed [IB-1:0] acc_r;
  logic                 neg_r;
  logic                 ovf_r;
  logic [15:0]          omega_r;
  logic [31:0]          k0_r;
  logic [31:0]          kp_r;
  logic [31:0]          ki_r;
  logic [chpi_pkg::TERM_W-1:0]  tp_r;
  logic [chpi_pkg::TERM_W-1:0]  ti_r;
  logic [47:0]                  pp0_r;
  logic [AB-1:0]                roll_r;
  logic [chpi_pkg::MUL_P_W-1:0] product_r;
  logic                         cmd_valid_r;
  logic [AB-1:0]                roll_out_r;
  logic [AB-1:0]                err_out_r;
  logic [IB-1:0]                int_out_r;

  logic signed [AB:0]           esum;
  logic [AB:0]                  esum_mag;
  logic [AB-1:0]                e_mag;
  logic [IB-1:0]                acc_mag;
  logic [63:0]                  mag64;
  logic [chpi_pkg::MUL_A_W-1:0] mul_a;
  logic [chpi_pkg::MUL_B_W-1:0] mul_b;
  logic                         mul_en;
  logic signed [PROD_W-1:0]     prod_s;
  logic signed [PROD_W-1:0]     prod_v;
  logic signed [PROD_W-1:0]     delta;
  logic signed [SW-1:0]         acc_sum;
  logic [IB-1:0]                acc_sat;
  logic                         div_start;
  logic                         div_k0;
  logic [15:0]                  div_rem_init;
  logic [31:0]                  div_lo;
  logic [15:0]                  div_divisor;
  logic [chpi_pkg::DIV_CNT_W-1:0] div_steps;
  logic                         div_busy;
  logic [31:0]                  div_q;
  logic                         ti_big;
  logic [chpi_pkg::TERM_W-1:0]  ti_sum;
  logic [chpi_pkg::TERM_W-1:0]  ti_val;
  logic signed [63:0]           tp_s;
  logic signed [63:0]           ti_s;
  logic signed [63:0]           roll_sum;
  logic signed [63:0]           roll_sh;
  logic [AB-1:0]                roll_cl;

  assign esum     = $signed({e_r[AB-1], e_r}) + $signed({prev_r[AB-1], prev_r});
  assign esum_mag = esum[AB] ? -esum : esum;
  assign e_mag    = e_r[AB-1] ? -e_r : e_r;
  assign acc_mag  = acc_r[IB-1] ? -acc_r : acc_r;
  assign mag64    = 64'(acc_mag);

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      chpi_pkg::OP_MUL_INT: begin
        mul_a = chpi_pkg::MUL_A_W'(esum_mag);
        mul_b = chpi_pkg::MUL_B_W'(dt_r);
      end
      chpi_pkg::OP_MUL_OV: begin
        mul_a = chpi_pkg::MUL_A_W'(omega_r);
        mul_b = chpi_pkg::MUL_B_W'(speed_r);
      end
      chpi_pkg::OP_MUL_KP: begin
        mul_a = chpi_pkg::MUL_A_W'(gains.zeta);
        mul_b = k0_r;
      end
      chpi_pkg::OP_MUL_KI: begin
        mul_a = chpi_pkg::MUL_A_W'(omega_r);
        mul_b = k0_r;
      end
      chpi_pkg::OP_MUL_TP: begin
        mul_a = chpi_pkg::MUL_A_W'(e_mag);
        mul_b = kp_r;
      end
      chpi_pkg::OP_MUL_T0: begin
        mul_a = chpi_pkg::MUL_A_W'(mag64[31:0]);
        mul_b = ki_r;
      end
      chpi_pkg::OP_MUL_T1: begin
        mul_a = chpi_pkg::MUL_A_W'(mag64[63:32]);
        mul_b = ki_r;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // trapezoid step and saturating accumulate
  assign prod_s  = $signed({1'b0, product_r[AB+16:0]});
  assign prod_v  = neg_r ? -prod_s : prod_s;
  assign delta   = prod_v >>> 1;
  assign acc_sum = SW'(acc_r) + SW'(delta);
  assign acc_sat = (acc_sum > IMAX) ? IMAX[IB-1:0] :
                   (acc_sum < IMIN) ? IMIN[IB-1:0] : acc_sum[IB-1:0];

  assign div_k0       = (cmd.op == chpi_pkg::OP_K0_START);
  assign div_start    = div_k0 || (cmd.op == chpi_pkg::OP_INT_ACC);
  assign div_rem_init = div_k0 ? 16'(product_r[31:22]) : 16'(gains.rnf[15:4]);
  assign div_lo       = div_k0 ? {product_r[21:0], 10'b0} : {gains.rnf[3:0], 28'b0};
  assign div_divisor  = div_k0 ? grav_r : gains.sep;
  assign div_steps    = div_k0 ? chpi_pkg::K0_STEPS : chpi_pkg::OMEGA_STEPS;

  chpi_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .rem_init    (div_rem_init),
    .dividend_lo (div_lo),
    .divisor     (div_divisor),
    .steps       (div_steps),
    .busy        (div_busy),
    .quotient    (div_q)
  );

  assign stat.div_busy = div_busy;

  // integral term from two partial products
  assign ti_big = |product_r[chpi_pkg::MUL_P_W-1:45];
  assign ti_sum = chpi_pkg::TERM_W'({product_r[44:0], 16'b0}) + chpi_pkg::TERM_W'(pp0_r);
  assign ti_val = (ti_big || (ti_sum >= chpi_pkg::TERM_CAP)) ? chpi_pkg::TERM_CAP : ti_sum;

  assign tp_s     = e_r[AB-1] ? -$signed(64'(tp_r)) : $signed(64'(tp_r));
  assign ti_s     = acc_r[IB-1] ? -$signed(64'(ti_r)) : $signed(64'(ti_r));
  assign roll_sum = tp_s + ti_s;
  assign roll_sh  = roll_sum >>> 16;
  assign roll_cl  = (roll_sh > RMAX) ? RMAX[AB-1:0] :
                    (roll_sh < RMIN) ? RMIN[AB-1:0] : roll_sh[AB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      prev_r <= '0;
    end else if (clear) begin
      acc_r  <= '0;
      prev_r <= '0;
    end else if (cmd.op == chpi_pkg::OP_INT_ACC) begin
      acc_r  <= acc_sat;
      prev_r <= e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      product_r <= mul_a * mul_b;
    end
    if (div_start) begin
      ovf_r <= div_rem_init >= div_divisor;
    end
    case (cmd.op)
      chpi_pkg::OP_LOAD: begin
        course_r <= in_course_angle;
        speed_r  <= in_ground_speed;
        grav_r   <= in_gravity_accel;
        dt_r     <= in_time_step;
      end
      chpi_pkg::OP_ERR:     e_r   <= target - course_r;
      chpi_pkg::OP_MUL_INT: neg_r <= esum[AB];
      chpi_pkg::OP_OM_CAP:  omega_r <= ovf_r ? 16'hFFFF : div_q[15:0];
      chpi_pkg::OP_K0_CAP:  k0_r <= ovf_r ? 32'hFFFF_FFFF : div_q;
      chpi_pkg::OP_MUL_KI:
        kp_r <= (|product_r[chpi_pkg::MUL_P_W-1:43]) ? 32'hFFFF_FFFF : product_r[42:11];
      chpi_pkg::OP_MUL_TP:
        ki_r <= (|product_r[chpi_pkg::MUL_P_W-1:44]) ? 32'hFFFF_FFFF : product_r[43:12];
      chpi_pkg::OP_MUL_T0:
        tp_r <= (product_r >= chpi_pkg::MUL_P_W'(chpi_pkg::TERM_CAP)) ?
                chpi_pkg::TERM_CAP : product_r[chpi_pkg::TERM_W-1:0];
      chpi_pkg::OP_MUL_T1:  pp0_r  <= product_r[63:16];
      chpi_pkg::OP_TI:      ti_r   <= ti_val;
      chpi_pkg::OP_ROLL:    roll_r <= roll_cl;
      chpi_pkg::OP_OUT: begin
        if (cmd.out_zero) begin
          cmd_valid_r <= 1'b0;
          roll_out_r  <= '0;
          err_out_r   <= '0;
          int_out_r   <= '0;
        end else begin
          cmd_valid_r <= 1'b1;
          roll_out_r  <= roll_r;
          err_out_r   <= e_r;
          int_out_r   <= acc_r;
        end
      end
      default: ;
    endcase
  end

  assign out_command_valid  = cmd_valid_r;
  assign out_roll_command   = roll_out_r;
  assign out_course_error   = err_out_r;
  assign out_error_integral = int_out_r;

endmodule

// ===== design/chpi_ctrl.sv =====
module chpi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            enable,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  chpi_pkg::stat_t stat,
  output chpi_pkg::cmd_t  cmd
);

  typedef enum logic [17:0] {
    ST_IDLE    = 18'h00001,
    ST_ERR     = 18'h00002,
    ST_MUL_INT = 18'h00004,
    ST_INT_ACC = 18'h00008,
    ST_DIV_OM  = 18'h00010,
    ST_OM_CAP  = 18'h00020,
    ST_MUL_OV  = 18'h00040,
    ST_K0_LOAD = 18'h00080,
    ST_DIV_K0  = 18'h00100,
    ST_K0_CAP  = 18'h00200,
    ST_MUL_KP  = 18'h00400,
    ST_MUL_KI  = 18'h00800,
    ST_MUL_TP  = 18'h01000,
    ST_MUL_T0  = 18'h02000,
    ST_MUL_T1  = 18'h04000,
    ST_TI      = 18'h08000,
    ST_ROLL    = 18'h10000,
    ST_DONE    = 18'h20000
  } state_t;

  state_t state_r, state_nxt;
  logic   skip_r, skip_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    skip_nxt      = skip_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = chpi_pkg::OP_IDLE;
    cmd.out_zero  = skip_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = chpi_pkg::OP_LOAD;
          skip_nxt  = !enable;
          state_nxt = enable ? ST_ERR : ST_DONE;
        end
      end
      ST_ERR: begin
        cmd.op    = chpi_pkg::OP_ERR;
        state_nxt = ST_MUL_INT;
      end
      ST_MUL_INT: begin
        cmd.op    = chpi_pkg::OP_MUL_INT;
        state_nxt = ST_INT_ACC;
      end
      ST_INT_ACC: begin
        cmd.op    = chpi_pkg::OP_INT_ACC;
        state_nxt = ST_DIV_OM;
      end
      ST_DIV_OM: begin
        if (!stat.div_busy) begin
          state_nxt = ST_OM_CAP;
        end
      end
      ST_OM_CAP: begin
        cmd.op    = chpi_pkg::OP_OM_CAP;
        state_nxt = ST_MUL_OV;
      end
      ST_MUL_OV: begin
        cmd.op    = chpi_pkg::OP_MUL_OV;
        state_nxt = ST_K0_LOAD;
      end
      ST_K0_LOAD: begin
        cmd.op    = chpi_pkg::OP_K0_START;
        state_nxt = ST_DIV_K0;
      end
      ST_DIV_K0: begin
        if (!stat.div_busy) begin
          state_nxt = ST_K0_CAP;
        end
      end
      ST_K0_CAP: begin
        cmd.op    = chpi_pkg::OP_K0_CAP;
        state_nxt = ST_MUL_KP;
      end
      ST_MUL_KP: begin
        cmd.op    = chpi_pkg::OP_MUL_KP;
        state_nxt = ST_MUL_KI;
      end
      ST_MUL_KI: begin
        cmd.op    = chpi_pkg::OP_MUL_KI;
        state_nxt = ST_MUL_TP;
      end
      ST_MUL_TP: begin
        cmd.op    = chpi_pkg::OP_MUL_TP;
        state_nxt = ST_MUL_T0;
      end
      ST_MUL_T0: begin
        cmd.op    = chpi_pkg::OP_MUL_T0;
        state_nxt = ST_MUL_T1;
      end
      ST_MUL_T1: begin
        cmd.op    = chpi_pkg::OP_MUL_T1;
        state_nxt = ST_TI;
      end
      ST_TI: begin
        cmd.op    = chpi_pkg::OP_TI;
        state_nxt = ST_ROLL;
      end
      ST_ROLL: begin
        cmd.op    = chpi_pkg::OP_ROLL;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.op        = chpi_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/course_hold_pi_controller.sv =====
// Course-hold PI controller: each input transfer (course, ground speed, gravity, time step)
// gives one output transfer with the saturated roll command, the wrapped course error and
// the trapezoidal error integral. A new transfer is taken only once the last result is in
// the output register; while enabled the time to the result is set mostly by the
// one-bit-a-cycle divider (16 steps for the roll/course frequency ratio, 32 for the
// speed/gravity gain) and by the single shared multiplier used seven times in turn. With
// the controller disabled a tick yields an all-zero result. Each result waits in an output
// register while the next tick is taken. A rising enable clears the integral and the
// previous error; write settings only while no tick is in flight: the block does not check.
module course_hold_pi_controller #(
  parameter int ANGLE_BITS    = 16,
  parameter int INTEGRAL_BITS = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [chpi_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [((ANGLE_BITS > 16) ? ANGLE_BITS : 16)-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ANGLE_BITS-1:0]            in_course_angle,
  input  logic [15:0]                      in_ground_speed,
  input  logic [15:0]                      in_gravity_accel,
  input  logic [15:0]                      in_time_step,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_command_valid,
  output logic signed [ANGLE_BITS-1:0]     out_roll_command,
  output logic signed [ANGLE_BITS-1:0]     out_course_error,
  output logic signed [INTEGRAL_BITS-1:0]  out_error_integral
);

  logic                  enable;
  logic                  clear;
  logic [ANGLE_BITS-1:0] target;
  chpi_pkg::gains_t      gains;
  chpi_pkg::cmd_t        cmd;
  chpi_pkg::stat_t       stat;

  chpi_cfg #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .enable    (enable),
    .clear     (clear),
    .target    (target),
    .gains     (gains)
  );

  chpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (enable),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  chpi_dp #(
    .ANGLE_BITS    (ANGLE_BITS),
    .INTEGRAL_BITS (INTEGRAL_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .clear              (clear),
    .target             (target),
    .gains              (gains),
    .in_course_angle    (in_course_angle),
    .in_ground_speed    (in_ground_speed),
    .in_gravity_accel   (in_gravity_accel),
    .in_time_step       (in_time_step),
    .out_command_valid  (out_command_valid),
    .out_roll_command   (out_roll_command),
    .out_course_error   (out_course_error),
    .out_error_integral (out_error_integral)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam longint          INTEG_MAX   = (64'sd1 <<< 47) - 64'sd1;
  localparam longint          INTEG_MIN   = -(64'sd1 <<< 47);
  localparam longint unsigned MAG_CAP     = 64'h2000_0000_0000_0000;
  localparam longint unsigned U32_MAX     = 64'h0000_0000_FFFF_FFFF;
  localparam longint          ROLL_MAX    = 64'sd32767;
  localparam longint          ROLL_MIN    = -64'sd32768;
  localparam int              MAX_REPORTS = 10;
  localparam int              CYCLE_LIMIT = 3_000_000;
  localparam int              PHASES      = 12;
  localparam logic [2:0]      REG_BEYOND  = chpi_pkg::REG_DAMPING + 3'd1;

  typedef struct packed {
    logic [15:0] course;
    logic [15:0] speed;
    logic [15:0] gravity;
    logic [15:0] step;
  } tick_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [15:0] roll;
    logic [15:0] err;
    logic [47:0] integ;
  } roll_cmd_t;

  class roll_scoreboard;
    logic        enabled;
    logic [15:0] target;
    logic [15:0] rnf;
    logic [15:0] sep;
    logic [15:0] zeta;
    longint      integ;
    longint      prev_err;
    roll_cmd_t   expected_cmds[$];
    int          mismatches;

    function new();
      enabled    = 1'b0;
      target     = '0;
      rnf        = chpi_pkg::RNF_RESET;
      sep        = chpi_pkg::SEP_RESET;
      zeta       = chpi_pkg::ZETA_RESET;
      integ      = 0;
      prev_err   = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] value);
      case (idx)
        chpi_pkg::REG_ENABLE: begin
          if (value[0] && !enabled) begin
            integ    = 0;
            prev_err = 0;
          end
          enabled = value[0];
        end
        chpi_pkg::REG_TARGET:  target = value;
        chpi_pkg::REG_RNF:     rnf = value;
        chpi_pkg::REG_SEP:     sep = value;
        chpi_pkg::REG_DAMPING: zeta = value;
        default: ;
      endcase
    endfunction

    function longint unsigned sat32(longint unsigned v);
      return (v > U32_MAX) ? U32_MAX : v;
    endfunction

    function longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // gain times magnitude, 16 fractional bits dropped, capped
    function longint unsigned term_mag(longint unsigned k, longint unsigned m);
      longint unsigned hi;
      longint unsigned lo;
      longint unsigned t;
      hi = m >> 16;
      lo = m & 64'hFFFF;
      if (hi != 0 && k > MAG_CAP / hi)
        return MAG_CAP;
      t = k * hi + ((k * lo) >> 16);
      return (t > MAG_CAP) ? MAG_CAP : t;
    endfunction

    function void note_tick(tick_t t);
      roll_cmd_t       r;
      logic [15:0]     d;
      longint          e;
      longint          delta;
      longint          acc_n;
      longint          sp;
      longint          si;
      longint          roll;
      longint unsigned omega;
      longint unsigned k0;
      longint unsigned kp;
      longint unsigned ki;
      longint unsigned tp;
      longint unsigned ti;
      r = '0;
      if (enabled) begin
        d     = target - t.course;
        e     = longint'($signed(d));
        delta = (longint'(t.step) * (e + prev_err)) >>> 1;
        if (delta > 0 && integ > INTEG_MAX - delta)
          acc_n = INTEG_MAX;
        else if (delta < 0 && integ < INTEG_MIN - delta)
          acc_n = INTEG_MIN;
        else
          acc_n = integ + delta;
        integ    = acc_n;
        prev_err = e;

        if (sep == 0) begin
          omega = 64'hFFFF;
        end else begin
          omega = (64'(rnf) << 12) / 64'(sep);
          if (omega > 64'hFFFF)
            omega = 64'hFFFF;
        end
        if (t.gravity == 0)
          k0 = U32_MAX;
        else
          k0 = sat32(((omega * 64'(t.speed)) << 10) / 64'(t.gravity));
        kp = sat32((64'(zeta) * k0) >> 11);
        ki = sat32((omega * k0) >> 12);

        tp   = term_mag(kp, mag(e) << 16);
        ti   = term_mag(ki, mag(acc_n));
        sp   = (e < 0) ? -longint'(tp) : longint'(tp);
        si   = (acc_n < 0) ? -longint'(ti) : longint'(ti);
        roll = (sp + si) >>> 16;
        if (roll > ROLL_MAX)
          roll = ROLL_MAX;
        if (roll < ROLL_MIN)
          roll = ROLL_MIN;

        r.cmd_valid = 1'b1;
        r.roll      = roll[15:0];
        r.err       = e[15:0];
        r.integ     = acc_n[47:0];
      end
      expected_cmds.push_back(r);
    endfunction

    function void check_cmd(roll_cmd_t got);
      roll_cmd_t want;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected roll command transfer: %h", got);
        return;
      end
      want = expected_cmds.pop_front();
      if (got.cmd_valid !== want.cmd_valid || got.roll !== want.roll ||
          got.err !== want.err || got.integ !== want.integ) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("roll command mismatch (expected/actual): valid %b/%b roll %0d/%0d",
                   want.cmd_valid, got.cmd_valid, $signed(want.roll), $signed(got.roll),
                   " error %0d/%0d integral %0d/%0d",
                   $signed(want.err), $signed(got.err),
                   $signed(want.integ), $signed(got.integ));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_course_angle = '0;
  logic [15:0] in_ground_speed = '0;
  logic [15:0] in_gravity_accel = '0;
  logic [15:0] in_time_step = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_command_valid;
  logic signed [15:0] out_roll_command;
  logic signed [15:0] out_course_error;
  logic signed [47:0] out_error_integral;

  int in_idle_pct = 31;
  int out_idle_pct = 31;
  int cycle_count;

  roll_scoreboard sb = new();

  course_hold_pi_controller i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_course_angle    (in_course_angle),
    .in_ground_speed    (in_ground_speed),
    .in_gravity_accel   (in_gravity_accel),
    .in_time_step       (in_time_step),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_command_valid  (out_command_valid),
    .out_roll_command   (out_roll_command),
    .out_course_error   (out_course_error),
    .out_error_integral (out_error_integral)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_cmd(roll_cmd_t'({out_command_valid, out_roll_command, out_course_error,
                                  out_error_integral}));
      if (in_valid && !in_stall)
        sb.note_tick(tick_t'({in_course_angle, in_ground_speed, in_gravity_accel,
                              in_time_step}));
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // entered and left at a falling edge
  task automatic send_tick(tick_t t);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_course_angle  <= t.course;
    in_ground_speed  <= t.speed;
    in_gravity_accel <= t.gravity;
    in_time_step     <= t.step;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_setting(logic [2:0] idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // wait until every transfer sent so far has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    if ($urandom_range(99) < 60) begin
      t.course  = sb.target + 16'($urandom_range(8191)) - 16'd4096;
      t.speed   = 16'($urandom_range(6400));
      t.gravity = 16'($urandom_range(30000, 50000));
      t.step    = 16'($urandom_range(1, 6554));
    end else begin
      t = tick_t'({$urandom, $urandom});
    end
    if ($urandom_range(49) == 0)
      t.gravity = '0;
    if ($urandom_range(49) == 0)
      t.step = '0;
    return t;
  endfunction

  task automatic config_phase(int p);
    logic [15:0] rnf;
    logic [15:0] sep;
    logic [15:0] zeta;
    rnf  = $urandom_range(1) ? 16'($urandom_range(2048, 16384)) : 16'($urandom);
    sep  = $urandom_range(1) ? 16'($urandom_range(4096, 40960)) : 16'($urandom);
    zeta = $urandom_range(1) ? 16'($urandom_range(1000, 8192)) : 16'($urandom);
    case (p)
      1: sep = '0;
      2: begin
        rnf = '1;
        sep = 16'd1;
      end
      3: rnf = '0;
      4: zeta = '1;
      5: zeta = '0;
      6: sep = '1;
      default: ;
    endcase
    write_setting(chpi_pkg::REG_RNF, rnf);
    write_setting(chpi_pkg::REG_SEP, sep);
    write_setting(chpi_pkg::REG_DAMPING, zeta);
    write_setting(chpi_pkg::REG_TARGET, 16'($urandom));
    write_setting(REG_BEYOND + 3'($urandom_range(2)), 16'($urandom));
    if (p == 7) begin
      write_setting(chpi_pkg::REG_ENABLE, 16'($urandom) & 16'hFFFE);
    end else begin
      if ($urandom_range(1))
        write_setting(chpi_pkg::REG_ENABLE, 16'h0000);
      write_setting(chpi_pkg::REG_ENABLE, 16'($urandom) | 16'h0001);
    end
  endtask

  initial begin
    tick_t dir_ticks[$];
    int    n;
    dir_ticks = '{
      {16'd0,     16'd1280,  16'd40181, 16'd656},
      {16'd1,     16'd1280,  16'd40181, 16'd656},
      {16'd65535, 16'd1280,  16'd40181, 16'd656},
      {16'd32768, 16'd1280,  16'd40181, 16'd656},
      {16'd32769, 16'd65535, 16'd40181, 16'd65535},
      {16'd32767, 16'd0,     16'd40181, 16'd65535},
      {16'd16384, 16'd1280,  16'd0,     16'd1},
      {16'd49152, 16'd1280,  16'd1,     16'd0},
      {16'd100,   16'd65535, 16'd65535, 16'd65535},
      {16'd65436, 16'd6400,  16'd4096,  16'd6554}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // disabled after reset: all-zero results, odd writes ignored
    send_tick({16'd1234, 16'd1280, 16'd40181, 16'd656});
    send_tick({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    settle();
    write_setting(REG_BEYOND, 16'hFFFF);
    write_setting(REG_BEYOND + 3'd2, 16'h5A5A);
    write_setting(chpi_pkg::REG_ENABLE, 16'hFFFE);
    send_tick({16'd4000, 16'd1280, 16'd40181, 16'd656});
    settle();

    write_setting(chpi_pkg::REG_TARGET, 16'd0);
    write_setting(chpi_pkg::REG_ENABLE, 16'd1);
    foreach (dir_ticks[i])
      send_tick(dir_ticks[i]);
    settle();

    // disable keeps the state, re-enable clears it, a repeated enable does not
    write_setting(chpi_pkg::REG_ENABLE, 16'd0);
    send_tick({16'd300, 16'd1280, 16'd40181, 16'd656});
    settle();
    write_setting(chpi_pkg::REG_ENABLE, 16'd0);
    write_setting(chpi_pkg::REG_ENABLE, 16'd1);
    send_tick({16'd300, 16'd1280, 16'd40181, 16'd656});
    settle();
    write_setting(chpi_pkg::REG_ENABLE, 16'd1);
    send_tick({16'd65000, 16'd1280, 16'd40181, 16'd656});
    settle();

    // zero separation ratio
    write_setting(chpi_pkg::REG_TARGET, 16'hFFFF);
    write_setting(chpi_pkg::REG_SEP, 16'd0);
    send_tick({16'd0, 16'd1280, 16'd40181, 16'd656});
    send_tick({16'd32767, 16'd640, 16'd40181, 16'd65535});

    for (int p = 0; p < PHASES; p++) begin
      settle();
      config_phase(p);
      in_idle_pct  = (p == 9) ? 0 : 31;
      out_idle_pct = (p == 9) ? 0 : 31;
      n = 125 + $urandom_range(10);
      repeat (n) send_tick(rand_tick());
    end

    settle();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_cmds.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/chpi_pkg.sv
design/chpi_cfg.sv
design/chpi_div.sv
design/chpi_dp.sv
design/chpi_ctrl.sv
design/course_hold_pi_controller.sv
sim/tb_top.sv
